// ===== sv/chd_pkg.sv =====
// ----------------------------------------------------------------------------
// chd_pkg: shared types and constants for the character histogram
// Command and config structs, register map and report constants.
// ----------------------------------------------------------------------------
package chd_pkg;

  localparam int unsigned NumCodesDef  = 128;
  localparam int unsigned CountBitsDef = 8;

  localparam int unsigned CODE_W  = 7;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned DEC_W   = 10;  // holds the clamped decimal value
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned POS_W   = 3;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;

  localparam logic [DEC_W-1:0]  DEC_CLAMP   = 10'd999;
  localparam logic [DEC_W-1:0]  DEC_HUNDRED = 10'd100;
  localparam logic [DEC_W-1:0]  DEC_TEN     = 10'd10;
  localparam logic [BYTE_W-1:0] ASCII_ZERO  = 8'd48;

  localparam logic OP_COUNT   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // register map, index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_FIRST_CODE = 3'd0,
    REG_LAST_CODE  = 3'd1,
    REG_LINE_END   = 3'd2,
    REG_LINE_FEED  = 3'd3,
    REG_SEPARATOR  = 3'd4
  } reg_idx_e;

  localparam logic [CODE_W-1:0] RST_FIRST_CODE = 7'd33;
  localparam logic [CODE_W-1:0] RST_LAST_CODE  = 7'd127;
  localparam logic [BYTE_W-1:0] RST_LINE_END   = 8'd13;
  localparam logic [BYTE_W-1:0] RST_LINE_FEED  = 8'd10;
  localparam logic [BYTE_W-1:0] RST_SEPARATOR  = 8'd32;

  typedef enum logic [1:0] {
    CMD_COUNT   = 2'd0,
    CMD_TRIGGER = 2'd1,
    CMD_ADVANCE = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [CODE_W-1:0] code;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_slot_t;

  typedef struct packed {
    logic [CODE_W-1:0] first_code;
    logic [CODE_W-1:0] last_code;
    logic [BYTE_W-1:0] line_end;
    logic [BYTE_W-1:0] line_feed;
    logic [BYTE_W-1:0] separator;
  } cfg_t;

endpackage

// ===== sv/char_histogram_with_dump_core.sv =====
// Path: an advance item's byte passes the intake register, queue and output register
//   before it is strobed; a trigger, or the advance that sends a record's line feed, adds
//   the range scan and the decimal conversion before its byte.
// Throughput: intake takes one item per cycle until its register and the two-entry queue
//   fill; the back end takes the next item only once it is back in its idle state.
// Reset: asynchronous, active low; counters read as zero at once; receiver cannot stall.
// ----------------------------------------------------------------------------
// char_histogram_with_dump_core: character histogram with report dump
// Counts 7-bit character codes in saturating counters; on the line-end code
// it streams a text report of nonzero counters in range, one byte per advance item.
// ----------------------------------------------------------------------------
module char_histogram_with_dump_core #(
  parameter int unsigned NUM_CODES  = chd_pkg::NumCodesDef,
  parameter int unsigned COUNT_BITS = chd_pkg::CountBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // item intake
  input  logic                       start,
  output logic                       busy,
  input  logic                       operation_i,
  input  logic [chd_pkg::CODE_W-1:0] char_code_i,
  // report bytes, one cycle each
  output logic                       result_strobe_o,
  output logic [chd_pkg::BYTE_W-1:0] out_byte_o,
  output logic                       dump_last_o,
  // APB config port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [chd_pkg::ADDR_W-1:0] paddr,
  input  logic [chd_pkg::DATA_W-1:0] pwdata,
  output logic [chd_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import chd_pkg::*;

  cfg_t      cfg_q;
  reg_idx_e  reg_idx;
  logic      cfg_we;
  logic      q_full;
  logic      q_pop;
  cmd_slot_t push_slot;
  cmd_slot_t head_slot;

  // --- configuration registers ---
  // No wait states; writes land on the access phase.
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_code <= RST_FIRST_CODE;
      cfg_q.last_code  <= RST_LAST_CODE;
      cfg_q.line_end   <= RST_LINE_END;
      cfg_q.line_feed  <= RST_LINE_FEED;
      cfg_q.separator  <= RST_SEPARATOR;
    end else if (cfg_we) begin
      // addresses past the last register are dropped
      unique case (reg_idx)
        REG_FIRST_CODE: cfg_q.first_code <= pwdata[CODE_W-1:0];
        REG_LAST_CODE:  cfg_q.last_code  <= pwdata[CODE_W-1:0];
        REG_LINE_END:   cfg_q.line_end   <= pwdata[BYTE_W-1:0];
        REG_LINE_FEED:  cfg_q.line_feed  <= pwdata[BYTE_W-1:0];
        REG_SEPARATOR:  cfg_q.separator  <= pwdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FIRST_CODE: prdata = DATA_W'(cfg_q.first_code);
      REG_LAST_CODE:  prdata = DATA_W'(cfg_q.last_code);
      REG_LINE_END:   prdata = DATA_W'(cfg_q.line_end);
      REG_LINE_FEED:  prdata = DATA_W'(cfg_q.line_feed);
      REG_SEPARATOR:  prdata = DATA_W'(cfg_q.separator);
      default:        prdata = '0;
    endcase
  end

  // --- front: intake register and classification ---
  // The line-end compare is here; the user must keep config static while items flow (not enforced).
  chd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .operation_i (operation_i),
    .char_code_i (char_code_i),
    .line_end_i  (cfg_q.line_end),
    .q_full_i    (q_full),
    .busy_o      (busy),
    .push_o      (push_slot)
  );

  // --- queue between front and back ---
  chd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_slot),
    .pop_i  (q_pop),
    .full_o (q_full),
    .head_o (head_slot)
  );

  // --- back: counter memory, scan, decimal conversion, byte output ---
  // Dump state (dumping flag, record position) lives here, so the
  // "ignore during dump" rules are applied in item order.
  chd_back #(
    .NUM_CODES  (NUM_CODES),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .head_i   (head_slot),
    .pop_o    (q_pop),
    .strobe_o (result_strobe_o),
    .byte_o   (out_byte_o),
    .last_o   (dump_last_o)
  );

endmodule

// ===== sv/chd_front.sv =====
// ----------------------------------------------------------------------------
// chd_front: item intake and classification
// Takes items, tags them count/trigger/advance and holds one for the queue.
// ----------------------------------------------------------------------------
module chd_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      operation_i,
  input  logic [chd_pkg::CODE_W-1:0] char_code_i,
  input  logic [chd_pkg::BYTE_W-1:0] line_end_i,
  input  logic                      q_full_i,
  output logic                      busy_o,
  output chd_pkg::cmd_slot_t        push_o
);
  import chd_pkg::*;

  logic      vld_q;
  cmd_t      cmd_q;
  cmd_t      cmd_d;
  logic      accept;
  logic      push;

  assign push   = vld_q && !q_full_i;
  assign busy_o = vld_q && q_full_i;
  assign accept = start_i && !busy_o;

  always_comb begin
    cmd_d.code = char_code_i;
    if (operation_i == OP_ADVANCE) begin
      cmd_d.kind = CMD_ADVANCE;
    end else if ({1'b0, char_code_i} == line_end_i) begin
      cmd_d.kind = CMD_TRIGGER;
    end else begin
      cmd_d.kind = CMD_COUNT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (accept) begin
      vld_q <= 1'b1;
    end else if (push) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

  assign push_o.valid = push;
  assign push_o.cmd   = cmd_q;

endmodule

// ===== sv/chd_queue.sv =====
// ----------------------------------------------------------------------------
// chd_queue: two-entry command queue
// Decouples intake from execution; head shown with a valid flag.
// ----------------------------------------------------------------------------
module chd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  chd_pkg::cmd_slot_t push_i,
  input  logic               pop_i,
  output logic               full_o,
  output chd_pkg::cmd_slot_t head_o
);
  import chd_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  cmd_t            ent_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push;
  logic            do_pop;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = ent_q[rd_ptr_q];
  assign do_push      = push_i.valid;
  assign do_pop       = pop_i && head_o.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= push_i.cmd;
    end
  end

endmodule

// ===== sv/chd_back.sv =====
// ----------------------------------------------------------------------------
// chd_back: counter memory, range scan and report generation
// Executes queued commands; scans for nonzero counters and builds records.
// ----------------------------------------------------------------------------
module chd_back #(
  parameter int unsigned NUM_CODES  = chd_pkg::NumCodesDef,
  parameter int unsigned COUNT_BITS = chd_pkg::CountBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  chd_pkg::cfg_t              cfg_i,
  input  chd_pkg::cmd_slot_t         head_i,
  output logic                       pop_o,
  output logic                       strobe_o,
  output logic [chd_pkg::BYTE_W-1:0] byte_o,
  output logic                       last_o
);
  import chd_pkg::*;

  localparam int unsigned IW = $clog2(NUM_CODES);
  localparam int unsigned SW = (IW + 1 > BYTE_W) ? IW + 1 : BYTE_W;
  localparam logic [SW-1:0]         TopCode  = SW'(NUM_CODES - 1);
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_CNT_WR   = 5'b00010,
    S_SCAN_RD  = 5'b00100,
    S_SCAN_CHK = 5'b01000,
    S_CONV     = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // counter store; valid bits make untouched entries read as zero
  logic [COUNT_BITS-1:0] cnt_mem [NUM_CODES];
  logic [NUM_CODES-1:0]  vld_q;
  logic [COUNT_BITS-1:0] rd_data_q;
  logic                  rd_vld_q;
  logic [IW-1:0]         rd_addr;
  logic                  wr_en;
  logic [COUNT_BITS-1:0] wr_data;
  logic [COUNT_BITS-1:0] rd_cnt;

  logic                  dumping_q, dumping_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic [IW-1:0]         scan_code_q, scan_code_d;
  logic [IW-1:0]         addr_q, addr_d;
  logic [SW-1:0]         scan_ptr_q, scan_ptr_d;
  logic                  trig_q, trig_d;
  logic [DEC_W-1:0]      rem_q, rem_d;
  logic [DIGIT_W-1:0]    hund_q, hund_d;
  logic [DIGIT_W-1:0]    tens_q, tens_d;
  logic                  strobe_q, strobe_d;
  logic [BYTE_W-1:0]     byte_q, byte_d;
  logic                  last_q, last_d;

  logic [SW-1:0]         code_ext;
  logic [SW-1:0]         hi;
  logic [DEC_W-1:0]      cnt_dec;
  logic [POS_W-1:0]      end_pos;
  logic [POS_W-1:0]      dig_k;
  logic [DIGIT_W-1:0]    digit;
  logic                  fin;
  logic                  fin_found;

  assign code_ext = SW'(head_i.cmd.code);
  assign hi       = (SW'(cfg_i.last_code) > TopCode) ? TopCode : SW'(cfg_i.last_code);
  assign rd_cnt   = rd_vld_q ? rd_data_q : '0;
  assign wr_data  = rd_cnt + 1'b1;
  assign cnt_dec  = DEC_W'(rd_cnt);
  assign rd_addr  = (state_q == S_SCAN_RD) ? scan_ptr_q[IW-1:0] : code_ext[IW-1:0];

  // record layout: code, separator, digits, line end, line feed
  assign end_pos = (hund_q != '0) ? 3'd5 : ((tens_q != '0) ? 3'd4 : 3'd3);
  assign dig_k   = end_pos - 3'd1 - pos_q;

  always_comb begin
    case (dig_k)
      3'd2:    digit = hund_q;
      3'd1:    digit = tens_q;
      default: digit = rem_q[DIGIT_W-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cnt_mem[addr_q] <= wr_data;
    end
    rd_data_q <= cnt_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[addr_q] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr];
    end
  end

  always_comb begin
    state_d     = state_q;
    dumping_d   = dumping_q;
    pos_d       = pos_q;
    scan_code_d = scan_code_q;
    addr_d      = addr_q;
    scan_ptr_d  = scan_ptr_q;
    trig_d      = trig_q;
    rem_d       = rem_q;
    hund_d      = hund_q;
    tens_d      = tens_q;
    strobe_d    = 1'b0;
    byte_d      = byte_q;
    last_d      = 1'b0;
    pop_o       = 1'b0;
    wr_en       = 1'b0;
    fin         = 1'b0;
    fin_found   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          unique case (head_i.cmd.kind)
            CMD_COUNT: begin
              if (!dumping_q && (code_ext <= TopCode)) begin
                addr_d  = code_ext[IW-1:0];
                state_d = S_CNT_WR;
              end
            end
            CMD_TRIGGER: begin
              if (!dumping_q) begin
                scan_ptr_d = SW'(cfg_i.first_code);
                trig_d     = 1'b1;
                state_d    = S_SCAN_RD;
              end
            end
            CMD_ADVANCE: begin
              if (dumping_q) begin
                if (pos_q > end_pos) begin
                  // line feed goes out once the next record is known
                  scan_ptr_d = SW'(scan_code_q) + 1'b1;
                  trig_d     = 1'b0;
                  state_d    = S_SCAN_RD;
                end else begin
                  strobe_d = 1'b1;
                  pos_d    = pos_q + 1'b1;
                  if (pos_q == 3'd0) begin
                    byte_d = BYTE_W'(scan_code_q);
                  end else if (pos_q == 3'd1) begin
                    byte_d = cfg_i.separator;
                  end else if (pos_q == end_pos) begin
                    byte_d = cfg_i.line_end;
                  end else begin
                    byte_d = ASCII_ZERO + BYTE_W'(digit);
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_CNT_WR: begin
        wr_en   = (rd_cnt != CountMax);
        state_d = S_IDLE;
      end
      S_SCAN_RD: begin
        if (scan_ptr_q > hi) begin
          fin = 1'b1;
        end else begin
          state_d = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (rd_cnt != '0) begin
          scan_code_d = scan_ptr_q[IW-1:0];
          rem_d       = (cnt_dec > DEC_CLAMP) ? DEC_CLAMP : cnt_dec;
          hund_d      = '0;
          tens_d      = '0;
          state_d     = S_CONV;
        end else begin
          scan_ptr_d = scan_ptr_q + 1'b1;
          state_d    = S_SCAN_RD;
        end
      end
      S_CONV: begin
        // one subtraction per cycle: hundreds first, then tens
        if (rem_q >= DEC_HUNDRED) begin
          rem_d  = rem_q - DEC_HUNDRED;
          hund_d = hund_q + 1'b1;
        end else if (rem_q >= DEC_TEN) begin
          rem_d  = rem_q - DEC_TEN;
          tens_d = tens_q + 1'b1;
        end else begin
          fin       = 1'b1;
          fin_found = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (fin) begin
      strobe_d  = 1'b1;
      byte_d    = trig_q ? cfg_i.line_end : cfg_i.line_feed;
      last_d    = !fin_found;
      dumping_d = fin_found;
      pos_d     = '0;
      state_d   = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      dumping_q <= 1'b0;
      pos_q     <= '0;
      strobe_q  <= 1'b0;
      last_q    <= 1'b0;
      hund_q    <= '0;
      tens_q    <= '0;
    end else begin
      state_q   <= state_d;
      dumping_q <= dumping_d;
      pos_q     <= pos_d;
      strobe_q  <= strobe_d;
      last_q    <= last_d;
      hund_q    <= hund_d;
      tens_q    <= tens_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_code_q <= scan_code_d;
    addr_q      <= addr_d;
    scan_ptr_q  <= scan_ptr_d;
    trig_q      <= trig_d;
    rem_q       <= rem_d;
    byte_q      <= byte_d;
  end

  assign strobe_o = strobe_q;
  assign byte_o   = byte_q;
  assign last_o   = last_q;

endmodule

// ===== sv/chd_checker.sv =====
// ----------------------------------------------------------------------------
// chd_checker: port-level checks for the character histogram
// Watches the top-level ports; attached by the bind below.
// ----------------------------------------------------------------------------
module chd_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic                       result_strobe_o,
  input logic                       dump_last_o,
  input logic                       pready
);

  // once reset has been seen at an edge, nothing is reported and intake is open
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> (!result_strobe_o && !busy))
    else $error("strobe or busy during reset");

  // last-byte flag only rides on a strobed byte
  a_last_strobed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dump_last_o |-> result_strobe_o)
    else $error("dump_last without strobe");

  // busy only rises right after an item was taken
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without an accepted item");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind char_histogram_with_dump_core chd_checker u_chd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .result_strobe_o (result_strobe_o),
  .dump_last_o     (dump_last_o),
  .pready          (pready)
);
